// File: rtl/core/rta_pkg.sv
// Shared types, constants and state codes of the rigid transform accumulator.
`default_nettype none
package rta_pkg;

    localparam int MATRIX_FRAC_BITS      = 30;
    localparam int TRANSLATION_FRAC_BITS = 16;
    localparam int CORDIC_ITERATIONS     = 24;
    localparam int ATAN_STEPS            = 30;

    localparam logic [1:0] KIND_ROTATE    = 2'd0;
    localparam logic [1:0] KIND_TRANSLATE = 2'd1;
    localparam logic [1:0] KIND_READ      = 2'd2;
    localparam logic [1:0] KIND_NONE      = 2'd3;
    localparam logic [1:0] AXIS_NONE      = 2'd3;
    localparam logic [1:0] ROW_HOMOG      = 2'd3;
    localparam logic [1:0] COL_TRANS      = 2'd3;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sh09B74EDA8;

    typedef struct packed {
        logic [1:0]         kind;
        logic [1:0]         axis;
        logic signed [31:0] angle;
        logic signed [31:0] dx;
        logic signed [31:0] dy;
        logic signed [31:0] dz;
        logic [1:0]         row;
        logic [1:0]         col;
    } t_in_beat;

    typedef struct packed {
        logic signed [31:0] value;
        logic               saturated;
    } t_out_beat;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_CS,
        ST_MUL,
        ST_ACC,
        ST_WRITE,
        ST_READ,
        ST_DONE
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load;       // capture the input beat
        logic       cordic_go;  // run one CORDIC step
        logic       cs_fin;     // round cos and sin
        logic       mul;        // form one product
        logic       acc;        // accumulate the product
        logic       wr;         // round, saturate and store a result
        logic       rd;         // form the read value
        logic [1:0] term;       // product index within the dot product
        logic [1:0] tgt;        // target row
        logic       sel;        // rotate: 0 for column n1, 1 for column n2
        logic [4:0] step;       // CORDIC step
    } t_cmd;

    typedef struct packed {
        logic [1:0] kind;
        logic [1:0] axis;
    } t_stat;

    function automatic logic signed [33:0] atan_entry(input logic [4:0] i);
        logic signed [33:0] v;
        unique case (i)
            5'd0:  v = 34'sh020000000; 5'd1:  v = 34'sh012E4051E;
            5'd2:  v = 34'sh009FB385B; 5'd3:  v = 34'sh0051111D4;
            5'd4:  v = 34'sh0028B0D43; 5'd5:  v = 34'sh00145D7E1;
            5'd6:  v = 34'sh000A2F61E; 5'd7:  v = 34'sh000517C55;
            5'd8:  v = 34'sh00028BE53; 5'd9:  v = 34'sh000145F2F;
            5'd10: v = 34'sh0000A2F98; 5'd11: v = 34'sh0000517CC;
            5'd12: v = 34'sh000028BE6; 5'd13: v = 34'sh0000145F3;
            5'd14: v = 34'sh00000A2FA; 5'd15: v = 34'sh00000517D;
            5'd16: v = 34'sh0000028BE; 5'd17: v = 34'sh00000145F;
            5'd18: v = 34'sh000000A30; 5'd19: v = 34'sh000000518;
            5'd20: v = 34'sh00000028C; 5'd21: v = 34'sh000000146;
            5'd22: v = 34'sh0000000A3; 5'd23: v = 34'sh000000051;
            5'd24: v = 34'sh000000029; 5'd25: v = 34'sh000000014;
            5'd26: v = 34'sh00000000A; 5'd27: v = 34'sh000000005;
            5'd28: v = 34'sh000000003; 5'd29: v = 34'sh000000001;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

// File: rtl/core/rta_ctrl.sv
// Sequencer of the rigid transform accumulator.
`default_nettype none
module rta_ctrl #(
    parameter int CORDIC_ITERATIONS = rta_pkg::CORDIC_ITERATIONS
) (
    input  wire               i_clk,
    input  wire               i_rst_n,
    input  wire               i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  wire               i_out_ready,
    input  rta_pkg::t_stat    i_stat,
    output rta_pkg::t_cmd     o_cmd
);
    localparam int STEPS = (CORDIC_ITERATIONS < rta_pkg::ATAN_STEPS) ?
                           CORDIC_ITERATIONS : rta_pkg::ATAN_STEPS;
    localparam logic [4:0] LAST_STEP = 5'(STEPS - 1);

    rta_pkg::t_state r_state, n_state;
    logic [4:0] r_step, n_step;
    logic [1:0] r_term, n_term;
    logic [1:0] r_tgt, n_tgt;
    logic       r_sel, n_sel;
    logic [1:0] last_term;

    assign last_term = (i_stat.kind == rta_pkg::KIND_TRANSLATE) ? 2'd2 : 2'd1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= rta_pkg::ST_IDLE;
            r_step  <= '0;
            r_term  <= '0;
            r_tgt   <= '0;
            r_sel   <= 1'b0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
            r_term  <= n_term;
            r_tgt   <= n_tgt;
            r_sel   <= n_sel;
        end
    end

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        n_term  = r_term;
        n_tgt   = r_tgt;
        n_sel   = r_sel;
        unique case (r_state)
            rta_pkg::ST_IDLE: begin
                if (i_in_valid) begin
                    n_state = rta_pkg::ST_READ;
                    n_step = '0; n_term = '0; n_tgt = '0; n_sel = 1'b0;
                end
            end
            rta_pkg::ST_READ: begin
                // Dispatch on the captured beat.
                if (i_stat.kind == rta_pkg::KIND_ROTATE && i_stat.axis != rta_pkg::AXIS_NONE)
                    n_state = rta_pkg::ST_CORDIC;
                else if (i_stat.kind == rta_pkg::KIND_TRANSLATE)
                    n_state = rta_pkg::ST_MUL;
                else
                    n_state = rta_pkg::ST_DONE;
            end
            rta_pkg::ST_CORDIC: begin
                n_step = r_step + 5'd1;
                if (r_step == LAST_STEP) n_state = rta_pkg::ST_CS;
            end
            rta_pkg::ST_CS: n_state = rta_pkg::ST_MUL;
            rta_pkg::ST_MUL: n_state = rta_pkg::ST_ACC;
            rta_pkg::ST_ACC: begin
                if (r_term == last_term) begin
                    n_state = rta_pkg::ST_WRITE;
                end else begin
                    n_term  = r_term + 2'd1;
                    n_state = rta_pkg::ST_MUL;
                end
            end
            rta_pkg::ST_WRITE: begin
                n_term  = '0;
                n_state = rta_pkg::ST_MUL;
                if (i_stat.kind == rta_pkg::KIND_ROTATE && !r_sel) begin
                    n_sel = 1'b1;
                end else begin
                    n_sel = 1'b0;
                    if (r_tgt == 2'd2) n_state = rta_pkg::ST_DONE;
                    else n_tgt = r_tgt + 2'd1;
                end
            end
            rta_pkg::ST_DONE: if (i_out_ready) n_state = rta_pkg::ST_IDLE;
            default: n_state = rta_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.term      = r_term;
        o_cmd.tgt       = r_tgt;
        o_cmd.sel       = r_sel;
        o_cmd.step      = r_step;
        o_in_ready      = 1'b0;
        o_out_valid     = 1'b0;
        unique case (r_state)
            rta_pkg::ST_IDLE: begin
                o_in_ready = 1'b1;
                o_cmd.load = i_in_valid;
            end
            rta_pkg::ST_READ:   o_cmd.rd = 1'b1;
            rta_pkg::ST_CORDIC: o_cmd.cordic_go = 1'b1;
            rta_pkg::ST_CS:     o_cmd.cs_fin = 1'b1;
            rta_pkg::ST_MUL:    o_cmd.mul = 1'b1;
            rta_pkg::ST_ACC:    o_cmd.acc = 1'b1;
            rta_pkg::ST_WRITE:  o_cmd.wr = 1'b1;
            rta_pkg::ST_DONE:   o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

// File: rtl/core/rta_dp.sv
// Datapath: CORDIC unit, shared multiplier, accumulator and transform state.
`default_nettype none
module rta_dp #(
    parameter int MATRIX_FRAC_BITS      = rta_pkg::MATRIX_FRAC_BITS,
    parameter int TRANSLATION_FRAC_BITS = rta_pkg::TRANSLATION_FRAC_BITS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  rta_pkg::t_in_beat  i_beat,
    input  rta_pkg::t_cmd      i_cmd,
    output rta_pkg::t_stat     o_stat,
    output rta_pkg::t_out_beat o_beat
);
    localparam int MF = MATRIX_FRAC_BITS;
    localparam logic signed [31:0] M_ONE = 32'sd1 <<< MF;
    localparam logic signed [31:0] T_ONE = 32'sd1 <<< TRANSLATION_FRAC_BITS;

    rta_pkg::t_in_beat r_in;
    logic signed [31:0] r_mat [9];
    logic signed [31:0] r_tv [3];
    logic signed [33:0] r_x, r_y, r_z;
    logic               r_flip;
    logic signed [31:0] r_c, r_s;
    logic signed [63:0] r_prod;
    logic signed [67:0] r_acc;
    logic signed [31:0] r_old;   // old column n1 value of the current row
    logic signed [31:0] r_val;
    logic               r_sat;

    logic [1:0] n1, n2;
    always_comb begin
        unique case (r_in.axis)
            2'd0: begin n1 = 2'd1; n2 = 2'd2; end
            2'd1: begin n1 = 2'd2; n2 = 2'd0; end
            default: begin n1 = 2'd0; n2 = 2'd1; end
        endcase
    end

    assign o_stat.kind = r_in.kind;
    assign o_stat.axis = r_in.axis;
    assign o_beat.value = r_val;
    assign o_beat.saturated = r_sat;

    // CORDIC step.
    logic signed [33:0] xs, ys, at;
    assign xs = r_x >>> i_cmd.step;
    assign ys = r_y >>> i_cmd.step;
    assign at = rta_pkg::atan_entry(i_cmd.step);

    function automatic logic signed [31:0] to_mfmt(input logic signed [34:0] v);
        logic signed [34:0] r;
        r = (v + (35'sd1 <<< (31 - MF))) >>> (32 - MF);
        if (r > 35'(M_ONE)) r = 35'(M_ONE);
        if (r < -35'(M_ONE)) r = -35'(M_ONE);
        return r[31:0];
    endfunction

    logic [31:0] ang_flip;
    logic        flip;
    assign flip = i_beat.angle[31] ^ i_beat.angle[30];
    assign ang_flip = flip ? (i_beat.angle ^ 32'h80000000) : i_beat.angle;

    // Multiplier operand selection.
    logic [3:0] base;
    logic signed [31:0] opa, opb;
    logic [1:0] col_a;
    assign base = 4'(i_cmd.tgt) * 4'd3;
    always_comb begin
        col_a = i_cmd.term;
        opb   = '0;
        if (r_in.kind == rta_pkg::KIND_TRANSLATE) begin
            col_a = i_cmd.term;
            unique case (i_cmd.term)
                2'd0: opb = r_in.dx;
                2'd1: opb = r_in.dy;
                default: opb = r_in.dz;
            endcase
        end else begin
            col_a = (i_cmd.term == 2'd0) ? n1 : n2;
            // n1 entry: c*v1 + s*v2;  n2 entry: -s*v1 + c*v2
            if (!i_cmd.sel) opb = (i_cmd.term == 2'd0) ? r_c : r_s;
            else            opb = (i_cmd.term == 2'd0) ? -r_s : r_c;
        end
        opa = r_mat[4'(base + 4'(col_a))];
        // When writing column n2, column n1 already holds its new value.
        if (r_in.kind == rta_pkg::KIND_ROTATE && i_cmd.sel && i_cmd.term == 2'd0)
            opa = r_old;
    end

    // Rounding and saturation of the accumulated dot product.
    logic signed [67:0] rnd, res;
    logic signed [31:0] res_sat;
    logic               clip;
    assign rnd = (r_acc + (68'sd1 <<< (MF - 1))) >>> MF;
    assign res = (r_in.kind == rta_pkg::KIND_TRANSLATE) ?
                 rnd + 68'(r_tv[i_cmd.tgt]) : rnd;
    always_comb begin
        clip = 1'b1;
        if (res > 68'sh7FFFFFFF) res_sat = 32'sh7FFFFFFF;
        else if (res < -68'sh80000000) res_sat = 32'sh80000000;
        else begin
            res_sat = res[31:0];
            clip = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++)
                r_mat[k] <= (k == 0 || k == 4 || k == 8) ? M_ONE : '0;
            for (int k = 0; k < 3; k++) r_tv[k] <= '0;
            r_sat <= 1'b0;
            r_val <= '0;
        end else begin
            if (i_cmd.load) begin
                r_in   <= i_beat;
                r_x    <= rta_pkg::CORDIC_GAIN;
                r_y    <= '0;
                r_z    <= 34'(signed'(ang_flip));
                r_flip <= flip;
                r_sat  <= 1'b0;
                r_val  <= '0;
                r_acc  <= '0;
            end
            if (i_cmd.cordic_go) begin
                if (!r_z[33]) begin
                    r_x <= r_x - ys; r_y <= r_y + xs; r_z <= r_z - at;
                end else begin
                    r_x <= r_x + ys; r_y <= r_y - xs; r_z <= r_z + at;
                end
            end
            if (i_cmd.cs_fin) begin
                r_c <= to_mfmt(r_flip ? -35'(r_x) : 35'(r_x));
                r_s <= to_mfmt(r_flip ? -35'(r_y) : 35'(r_y));
            end
            if (i_cmd.mul) r_prod <= 64'(opa) * 64'(opb);
            if (i_cmd.acc) r_acc <= r_acc + 68'(r_prod);
            if (i_cmd.wr) begin
                r_acc <= '0;
                if (clip) r_sat <= 1'b1;
                if (r_in.kind == rta_pkg::KIND_TRANSLATE) begin
                    r_tv[i_cmd.tgt] <= res_sat;
                end else if (!i_cmd.sel) begin
                    r_old <= r_mat[4'(base + 4'(n1))];
                    r_mat[4'(base + 4'(n1))] <= res_sat;
                end else begin
                    r_mat[4'(base + 4'(n2))] <= res_sat;
                end
            end
            if (i_cmd.rd && r_in.kind == rta_pkg::KIND_READ) begin
                if (r_in.row == rta_pkg::ROW_HOMOG)
                    r_val <= (r_in.col == rta_pkg::COL_TRANS) ? T_ONE : '0;
                else if (r_in.col == rta_pkg::COL_TRANS)
                    r_val <= r_tv[r_in.row];
                else
                    r_val <= r_mat[4'(4'(r_in.row) * 4'd3 + 4'(r_in.col))];
            end
        end
    end
endmodule
`default_nettype wire

// File: rtl/core/rigid_transform_accumulator.sv
// Rigid transform accumulator: a read beat is served by the read state, a rotate runs the
// CORDIC steps and then 6 two-term dot products on one shared multiplier, and a translate
// runs 3 three-term dot products. One beat is in flight at a time; the next beat is accepted
// in the cycle after the result is taken. Synchronous active-low reset restores identity
// rotation and zero translation at once.
`default_nettype none
module rigid_transform_accumulator #(
    parameter int MATRIX_FRAC_BITS      = rta_pkg::MATRIX_FRAC_BITS,
    parameter int TRANSLATION_FRAC_BITS = rta_pkg::TRANSLATION_FRAC_BITS,
    parameter int CORDIC_ITERATIONS     = rta_pkg::CORDIC_ITERATIONS
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  rta_pkg::t_in_beat  i_in_data,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output rta_pkg::t_out_beat o_out_data
);
    rta_pkg::t_cmd  cmd;
    rta_pkg::t_stat stat;

    rta_ctrl #(.CORDIC_ITERATIONS(CORDIC_ITERATIONS)) u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
        .i_stat(stat), .o_cmd(cmd)
    );

    rta_dp #(
        .MATRIX_FRAC_BITS(MATRIX_FRAC_BITS),
        .TRANSLATION_FRAC_BITS(TRANSLATION_FRAC_BITS)
    ) u_dp (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_beat(i_in_data), .i_cmd(cmd),
        .o_stat(stat), .o_beat(o_out_data)
    );
endmodule
`default_nettype wire

// File: sim/rigid_transform_accumulator_test.sv
// Self-checking testbench of the rigid transform accumulator with a built-in transform predictor.
`default_nettype none
module rigid_transform_accumulator_test;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 100;
    localparam int CALM_AFTER     = 1750;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_in_valid = 1'b0;
    logic i_out_ready = 1'b0;
    rta_pkg::t_in_beat i_in_data = '0;
    logic o_in_ready, o_out_valid;
    rta_pkg::t_out_beat o_out_data;

    rigid_transform_accumulator u_top (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_in_valid(i_in_valid), .o_in_ready(o_in_ready), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data)
    );

    always #1 i_clk = ~i_clk;

    rta_pkg::t_in_beat  pending_beats[$];
    rta_pkg::t_out_beat expected_results[$];
    logic signed [31:0] rot_m[9];
    logic signed [31:0] trans_v[3];
    bit stimulus_done = 0;
    bit calm_phase = 0;
    bit hold_done = 0;
    int accepted_beats = 0;
    int failures = 0;
    int idle_cycles = 0;
    int in_gap = 0;
    int out_gap = 0;
    int hold_left = 0;
    logic o_in_ready_seen = 1'b0;

    function automatic logic signed [63:0] floor_shift(logic signed [63:0] v, int s);
        return v >>> s;
    endfunction

    function automatic logic signed [63:0] clip32(logic signed [63:0] v, ref bit clipped);
        if (v > 64'sd2147483647) begin
            clipped = 1;
            return 64'sd2147483647;
        end
        if (v < -64'sd2147483648) begin
            clipped = 1;
            return -64'sd2147483648;
        end
        return v;
    endfunction

    function automatic logic signed [63:0] atan_step(int i);
        logic signed [63:0] tab[30];
        tab = '{64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4, 64'h028B0D43,
                64'h0145D7E1, 64'h00A2F61E, 64'h00517C55, 64'h0028BE53, 64'h00145F2F,
                64'h000A2F98, 64'h000517CC, 64'h00028BE6, 64'h000145F3, 64'h0000A2FA,
                64'h0000517D, 64'h000028BE, 64'h0000145F, 64'h00000A30, 64'h00000518,
                64'h0000028C, 64'h00000146, 64'h000000A3, 64'h00000051, 64'h00000029,
                64'h00000014, 64'h0000000A, 64'h00000005, 64'h00000003, 64'h00000001};
        return tab[i];
    endfunction

    function automatic logic signed [63:0] to_unit(logic signed [63:0] v);
        logic signed [63:0] one, r;
        one = 64'sd1 <<< rta_pkg::MATRIX_FRAC_BITS;
        r = floor_shift(v + (64'sd1 <<< (31 - rta_pkg::MATRIX_FRAC_BITS)),
                        32 - rta_pkg::MATRIX_FRAC_BITS);
        if (r > one) r = one;
        if (r < -one) r = -one;
        return r;
    endfunction

    task automatic sin_cos(input logic [31:0] ang, output logic signed [63:0] c,
                           output logic signed [63:0] s);
        bit flip;
        logic signed [63:0] x, y, z, xs, ys;
        flip = ((ang + 32'h40000000) & 32'h80000000) != 0;
        if (flip) ang = ang - 32'h80000000;
        x = 64'sh9B74EDA8;
        y = 0;
        z = {{32{ang[31]}}, ang};
        for (int i = 0; i < rta_pkg::CORDIC_ITERATIONS && i < rta_pkg::ATAN_STEPS; i++) begin
            xs = floor_shift(x, i);
            ys = floor_shift(y, i);
            if (z >= 0) begin
                x -= ys; y += xs; z -= atan_step(i);
            end else begin
                x += ys; y -= xs; z += atan_step(i);
            end
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = to_unit(x);
        s = to_unit(y);
    endtask

    // Exact sum of products, rounded half up once at the end.
    function automatic logic signed [63:0] round_dot(logic signed [63:0] a[3],
                                                     logic signed [63:0] b[3], int n);
        logic signed [63:0] q, r, p, pq, one;
        one = 64'sd1 <<< rta_pkg::MATRIX_FRAC_BITS;
        q = 0;
        r = 0;
        for (int k = 0; k < n; k++) begin
            p = a[k] * b[k];
            pq = floor_shift(p, rta_pkg::MATRIX_FRAC_BITS);
            q += pq;
            r += p - pq * one;
        end
        return q + floor_shift(r + (one >>> 1), rta_pkg::MATRIX_FRAC_BITS);
    endfunction

    task automatic predict_transform(input rta_pkg::t_in_beat b);
        rta_pkg::t_out_beat res;
        bit clipped;
        logic signed [63:0] c, s, v[3], k1[3], k2[3], d[3], rr[3];
        int n1, n2;
        clipped = 0;
        res = '0;
        if (b.kind == rta_pkg::KIND_ROTATE && b.axis != rta_pkg::AXIS_NONE) begin
            n1 = (b.axis + 1) % 3;
            n2 = (b.axis + 2) % 3;
            sin_cos(b.angle, c, s);
            k1 = '{c, s, 0};
            k2 = '{-s, c, 0};
            for (int i = 0; i < 3; i++) begin
                v = '{rot_m[i*3+n1], rot_m[i*3+n2], 0};
                rot_m[i*3+n1] = 32'(clip32(round_dot(v, k1, 2), clipped));
                rot_m[i*3+n2] = 32'(clip32(round_dot(v, k2, 2), clipped));
            end
        end else if (b.kind == rta_pkg::KIND_TRANSLATE) begin
            d = '{b.dx, b.dy, b.dz};
            for (int i = 0; i < 3; i++) begin
                rr = '{rot_m[i*3], rot_m[i*3+1], rot_m[i*3+2]};
                trans_v[i] = 32'(clip32(round_dot(rr, d, 3) + trans_v[i], clipped));
            end
        end else if (b.kind == rta_pkg::KIND_READ) begin
            if (b.row == rta_pkg::ROW_HOMOG)
                res.value = (b.col == rta_pkg::COL_TRANS) ?
                            (32'sd1 <<< rta_pkg::TRANSLATION_FRAC_BITS) : 32'sd0;
            else if (b.col == rta_pkg::COL_TRANS)
                res.value = trans_v[b.row];
            else
                res.value = rot_m[b.row*3 + b.col];
        end
        res.saturated = clipped;
        expected_results.push_back(res);
    endtask

    function automatic rta_pkg::t_in_beat random_beat();
        rta_pkg::t_in_beat b;
        b = '0;
        b.kind = $urandom_range(0, 99) < 3 ? rta_pkg::KIND_NONE : 2'($urandom_range(0, 2));
        b.axis = $urandom_range(0, 19) == 0 ? rta_pkg::AXIS_NONE : 2'($urandom_range(0, 2));
        b.angle = $urandom;
        // Mostly modest steps so the translation seldom pins at its rails.
        b.dx = $urandom_range(0, 9) == 0 ? $urandom : $signed(32'($urandom) >>> 8);
        b.dy = $urandom_range(0, 9) == 0 ? $urandom : $signed(32'($urandom) >>> 8);
        b.dz = $urandom_range(0, 9) == 0 ? $urandom : $signed(32'($urandom) >>> 8);
        b.row = 2'($urandom);
        b.col = 2'($urandom);
        return b;
    endfunction

    function automatic rta_pkg::t_in_beat make_beat(logic [1:0] k, logic [1:0] a,
                                                    logic [31:0] ang, logic [31:0] x,
                                                    logic [31:0] y, logic [31:0] z,
                                                    logic [1:0] r, logic [1:0] c);
        rta_pkg::t_in_beat b;
        b.kind = k; b.axis = a; b.angle = ang;
        b.dx = x; b.dy = y; b.dz = z; b.row = r; b.col = c;
        return b;
    endfunction

    initial begin
        logic [31:0] angles[6];
        for (int k = 0; k < 9; k++)
            rot_m[k] = (k == 0 || k == 4 || k == 8) ?
                       (32'sd1 <<< rta_pkg::MATRIX_FRAC_BITS) : 32'sd0;
        for (int k = 0; k < 3; k++)
            trans_v[k] = 32'sd0;
        angles = '{32'h0, 32'h40000000, 32'h80000000, 32'hC0000000, 32'h7FFFFFFF,
                   32'h3FFFFFFF};
        for (int r = 0; r < 4; r++)
            for (int c = 0; c < 4; c++)
                pending_beats.push_back(make_beat(rta_pkg::KIND_READ, 2'd0, 0, 0, 0, 0,
                                                  2'(r), 2'(c)));
        foreach (angles[i])
            pending_beats.push_back(make_beat(rta_pkg::KIND_ROTATE, 2'(i % 3), angles[i],
                                              0, 0, 0, 2'd0, 2'd0));
        pending_beats.push_back(make_beat(rta_pkg::KIND_ROTATE, rta_pkg::AXIS_NONE,
                                          32'h12345678, 0, 0, 0, 2'd0, 2'd0));
        pending_beats.push_back(make_beat(rta_pkg::KIND_NONE, 2'd0, 0, 0, 0, 0, 2'd0, 2'd0));
        pending_beats.push_back(make_beat(rta_pkg::KIND_TRANSLATE, 2'd0, 0, 32'h7FFFFFFF,
                                          32'h7FFFFFFF, 32'h7FFFFFFF, 2'd0, 2'd0));
        pending_beats.push_back(make_beat(rta_pkg::KIND_TRANSLATE, 2'd0, 0, 32'h80000000,
                                          32'h80000000, 32'h80000000, 2'd0, 2'd0));
        pending_beats.push_back(make_beat(rta_pkg::KIND_TRANSLATE, 2'd0, 0, 32'h80000000,
                                          32'h80000000, 32'h80000000, 2'd0, 2'd0));
        pending_beats.push_back(make_beat(rta_pkg::KIND_READ, 2'd0, 0, 0, 0, 0, 2'd0,
                                          rta_pkg::COL_TRANS));
        for (int i = 0; i < 1950; i++)
            pending_beats.push_back(random_beat());
        stimulus_done = 1;
    end

    // Driver: one beat offered at a time, held until accepted.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || o_in_ready_seen) begin
            if (in_gap > 0) begin
                in_gap <= in_gap - 1;
                i_in_valid <= 1'b0;
            end else if (pending_beats.size() > 0) begin
                if (!calm_phase && $urandom_range(0, 15) == 0) begin
                    in_gap <= $urandom_range(0, 18);
                    i_in_valid <= 1'b0;
                end else begin
                    i_in_data <= pending_beats.pop_front();
                    i_in_valid <= 1'b1;
                end
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // Acceptance seen at the last rising edge.
    always @(posedge i_clk) begin
        o_in_ready_seen <= i_in_valid && o_in_ready && i_rst_n;
        if (i_rst_n && i_in_valid && o_in_ready) begin
            predict_transform(i_in_data);
            accepted_beats <= accepted_beats + 1;
            calm_phase <= (accepted_beats + 1 >= CALM_AFTER);
        end
    end

    // Receiver back-pressure, with one long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else if (!hold_done && accepted_beats >= HOLD_AFTER && hold_left == 0 &&
                     out_gap == 0) begin
            hold_done <= 1;
            hold_left <= HOLD_CYCLES;
            i_out_ready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_out_ready <= (hold_left == 1);
        end else if (out_gap > 0) begin
            out_gap <= out_gap - 1;
            i_out_ready <= (out_gap == 1);
        end else if (!calm_phase && $urandom_range(0, 15) == 0) begin
            out_gap <= $urandom_range(1, 19);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        rta_pkg::t_out_beat exp_res;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result value=%0d saturated=%0b",
                       o_out_data.value, o_out_data.saturated);
                failures++;
            end else begin
                exp_res = expected_results.pop_front();
                if (o_out_data.value !== exp_res.value) begin
                    $error("value: expected %0d, actual %0d", exp_res.value, o_out_data.value);
                    failures++;
                end
                if (o_out_data.saturated !== exp_res.saturated) begin
                    $error("saturated: expected %0b, actual %0b",
                           exp_res.saturated, o_out_data.saturated);
                    failures++;
                end
            end
        end
    end

    // Watchdog on cycles without any beat moving.
    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready) || (o_out_valid && i_out_ready) || !i_rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        wait (stimulus_done);
        while (pending_beats.size() > 0 || i_in_valid || expected_results.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
        if (failures == 0 && expected_results.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end
endmodule
`default_nettype wire
